### src/dma_tag_tracker_completion_macros.svh
// Assertion macros for the DMA tag tracker.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef DMA_TAG_TRACKER_COMPLETION_MACROS_SVH
`define DMA_TAG_TRACKER_COMPLETION_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define DTTC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// antecedent implies consequent in the next cycle
`define DTTC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define DTTC_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define DTTC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

### src/dttc_pkg.sv
// Package for the DMA tag tracker: item and result types, command and
// status codes, outcome codes and the controller state type. No dependencies.
package dttc_pkg;

    localparam int NUM_TAGS_DEF  = 256;
    localparam int RING_SIZE_DEF = 256;

    // hardware command bytes
    localparam logic [7:0] CMD_DISCARD = 8'h70;
    localparam logic [7:0] CMD_WRITE   = 8'h80;
    localparam logic [7:0] CMD_READ    = 8'hC0;
    localparam logic [7:0] CMD_RECON   = 8'hE0;

    // hardware status bits
    localparam logic [7:0] ST_CRC   = 8'h01;
    localparam logic [7:0] ST_HARD  = 8'h02;
    localparam logic [7:0] ST_FAULT = 8'h08;

    // operation codes
    localparam logic OP_ISSUE  = 1'b0;
    localparam logic OP_STATUS = 1'b1;

    // outcome codes
    localparam logic [2:0] OC_ISSUED     = 3'd0;
    localparam logic [2:0] OC_NO_TAG     = 3'd1;
    localparam logic [2:0] OC_OK         = 3'd2;
    localparam logic [2:0] OC_FAULT      = 3'd3;
    localparam logic [2:0] OC_REQUEUE    = 3'd4;
    localparam logic [2:0] OC_SW_ERR     = 3'd5;
    localparam logic [2:0] OC_NO_TRACKER = 3'd6;
    localparam logic [2:0] OC_NOT_READY  = 3'd7;

    typedef struct packed {
        logic        op;
        logic [7:0]  command_in;
        logic [2:0]  sector_offset;
        logic [3:0]  sector_count;
        logic [31:0] blk_addr;
        logic [15:0] entry_count;
        logic [7:0]  dev_status;
        logic [7:0]  entry_tag;
    } t_item;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [7:0]  tag_out;
        logic [7:0]  ring_index;
        logic [7:0]  command_out;
        logic [7:0]  sect_byte;
        logic [31:0] blk_addr_out;
    } t_result;

    // payload of one tracker entry (valid bit kept apart in flops)
    typedef struct packed {
        logic [7:0]  cmd;
        logic [7:0]  sect;
        logic [31:0] addr;
    } t_trk;

    // classifier verdict
    typedef struct packed {
        logic [2:0] outcome;
        logic       requeue;
    } t_class;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

### src/dttc_classify.sv
// Completion status classifier: maps recorded command, hardware status and
// the scrub bit to an outcome code and requeue flag. Depends on dttc_pkg.
module dttc_classify (
    input  logic [7:0]      i_cmd,
    input  logic [7:0]      i_status,
    input  logic            i_scrub,
    output dttc_pkg::t_class o_class
);
    import dttc_pkg::*;

    logic media_err;

    assign media_err = |(i_status & (ST_CRC | ST_HARD));

    always_comb begin
        o_class.requeue = 1'b0;
        o_class.outcome = OC_OK;
        if (i_status != 8'h00) begin
            case (i_cmd) inside
                CMD_READ: begin
                    if (media_err) begin
                        o_class.outcome = i_scrub ? OC_REQUEUE : OC_FAULT;
                        o_class.requeue = i_scrub;
                    end else begin
                        o_class.outcome = |(i_status & ST_FAULT) ? OC_FAULT : OC_OK;
                    end
                end
                CMD_RECON: begin
                    o_class.outcome = media_err ? OC_FAULT : OC_OK;
                end
                CMD_WRITE, CMD_DISCARD: begin
                    o_class.outcome = OC_FAULT;
                end
                default: begin
                    o_class.outcome = OC_SW_ERR;
                end
            endcase
        end
    end

endmodule

### src/dma_tag_tracker_completion.sv
// Top level of the DMA tag tracker: free-list tag allocation, tracker memory
// and completion handling. Depends on dttc_pkg, dttc_classify and the macro header.
//
// Usage:
//   Items enter on i_item when i_start is high and o_busy is low. Op 0 issues
//   a command: a tag is popped from the LIFO free list, the command is
//   recorded in that tag's tracker entry and the tag, ring slot and packed
//   command fields come back. Op 1 presents a status ring entry: it is taken
//   only when its count matches the expected count, then the tracker entry is
//   looked up, the status classified and the tag pushed back on the free list.
//   Every item gives exactly one result on o_result, marked by o_done for one
//   cycle. The receiver cannot stall; results are never held.
//   The item and the tracker and link memory reads are registered at accept;
//   S_EXEC classifies, does the write-back and registers the result, which is
//   then shown. A new item may be accepted in the cycle the result is shown;
//   no new item is taken while one executes, as the registered read of the
//   free-list link must follow the head once it moves.
//   i_cfg_wr_en/i_cfg_wr_data write the scrub-on-read-error bit (reset 1).
//   Reset (synchronous, active low) empties all tracker entries, rebuilds the
//   free list in tag order and clears ring position and expected count.
`include "dma_tag_tracker_completion_macros.svh"

module dma_tag_tracker_completion #(
    parameter int NUM_TAGS  = dttc_pkg::NUM_TAGS_DEF,
    parameter int RING_SIZE = dttc_pkg::RING_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_start,
    output logic              o_busy,
    input  dttc_pkg::t_item   i_item,
    output logic              o_done,
    output dttc_pkg::t_result o_result
);
    import dttc_pkg::*;

    localparam int TAG_W  = $clog2(NUM_TAGS);
    localparam int RING_W = $clog2(RING_SIZE);

    t_state r_state, n_state;

    t_item              r_item;
    logic [TAG_W-1:0]   r_head, n_head;
    logic               r_head_none, n_head_none;
    logic [RING_W-1:0]  r_ring, n_ring;
    logic [15:0]        r_exp_count, n_exp_count;
    logic               r_scrub;
    logic [NUM_TAGS-1:0] r_valid;
    // tags at or above the fill mark were never taken and still link to the next tag
    logic [TAG_W:0]     r_fill, n_fill;

    // memories: link entry is {none, tag}
    logic [TAG_W:0]     link_mem [NUM_TAGS];
    logic [TAG_W:0]     r_link_rd;
    t_trk               trk_mem [NUM_TAGS];
    t_trk               r_trk_rd;

    t_result            r_result, n_result;
    logic               r_done, n_done;

    logic               accept;
    logic [TAG_W-1:0]   rd_tag;
    logic [TAG_W-1:0]   ex_tag;
    logic               tag_in_range;
    logic               tag_known;
    logic [TAG_W:0]     head_link;
    logic               trk_we;
    t_trk               trk_wdata;
    logic               link_we;
    logic               valid_set;
    logic               valid_clr;
    t_class             cls;

    assign accept = i_start && !o_busy;
    assign rd_tag = i_item.entry_tag[TAG_W-1:0];
    assign ex_tag = r_item.entry_tag[TAG_W-1:0];
    assign tag_in_range = ({1'b0, r_item.entry_tag} < 9'(NUM_TAGS));
    assign tag_known = tag_in_range && r_valid[ex_tag];

    // a tag at or above the fill mark has its reset link: next tag, last is none
    always_comb begin
        if ({1'b0, r_head} < r_fill) begin
            head_link = r_link_rd;
        end else if (r_head == TAG_W'(NUM_TAGS - 1)) begin
            head_link = {1'b1, {TAG_W{1'b0}}};
        end else begin
            head_link = {1'b0, r_head + TAG_W'(1)};
        end
    end

    dttc_classify u_classify (
        .i_cmd    (r_trk_rd.cmd),
        .i_status (r_item.dev_status),
        .i_scrub  (r_scrub),
        .o_class  (cls)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_head_none = r_head_none;
        n_ring      = r_ring;
        n_exp_count = r_exp_count;
        n_fill      = r_fill;
        n_result    = '0;
        n_done      = 1'b0;
        trk_we      = 1'b0;
        link_we     = 1'b0;
        valid_set   = 1'b0;
        valid_clr   = 1'b0;
        trk_wdata.cmd  = r_item.command_in;
        trk_wdata.sect = {1'b0, r_item.sector_count[2:0], 1'b0, r_item.sector_offset};
        trk_wdata.addr = r_item.blk_addr;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (r_item.op == OP_ISSUE) begin
                    if (r_head_none) begin
                        n_result.outcome = OC_NO_TAG;
                    end else begin
                        trk_we      = 1'b1;
                        valid_set   = 1'b1;
                        n_head      = head_link[TAG_W-1:0];
                        n_head_none = head_link[TAG_W];
                        // advance the fill mark past a tag taken for the first time
                        if ({1'b0, r_head} == r_fill) begin
                            n_fill = r_fill + (TAG_W+1)'(1);
                        end
                        n_ring      = (r_ring == RING_W'(RING_SIZE - 1)) ?
                                      '0 : r_ring + RING_W'(1);
                        n_result.outcome      = OC_ISSUED;
                        n_result.tag_out      = 8'(r_head);
                        n_result.ring_index   = 8'(r_ring);
                        n_result.command_out  = trk_wdata.cmd;
                        n_result.sect_byte    = trk_wdata.sect;
                        n_result.blk_addr_out = trk_wdata.addr;
                    end
                end else begin
                    if (r_item.entry_count != r_exp_count) begin
                        n_result.outcome = OC_NOT_READY;
                    end else if (!tag_known) begin
                        n_result.outcome = OC_NO_TRACKER;
                        n_result.tag_out = r_item.entry_tag;
                    end else begin
                        // complete: free the tag onto the list head
                        valid_clr   = 1'b1;
                        link_we     = 1'b1;
                        n_head      = ex_tag;
                        n_head_none = 1'b0;
                        n_exp_count = r_exp_count + 16'd1;
                        n_result.outcome      = cls.outcome;
                        n_result.tag_out      = r_item.entry_tag;
                        n_result.command_out  = cls.requeue ? CMD_RECON : r_trk_rd.cmd;
                        n_result.sect_byte    = r_trk_rd.sect;
                        n_result.blk_addr_out = r_trk_rd.addr;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_head_none <= 1'b0;
            r_ring      <= '0;
            r_exp_count <= '0;
            r_scrub     <= 1'b1;
            r_valid     <= '0;
            r_fill      <= '0;
            r_done      <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_head_none <= n_head_none;
            r_ring      <= n_ring;
            r_exp_count <= n_exp_count;
            r_fill      <= n_fill;
            r_done      <= n_done;
            if (i_cfg_wr_en) begin
                r_scrub <= i_cfg_wr_data;
            end
            if (valid_set) begin
                r_valid[r_head] <= 1'b1;
            end
            if (valid_clr) begin
                r_valid[ex_tag] <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_result <= n_result;
    end

    // free-list link memory, read at the head every cycle
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[ex_tag] <= {r_head_none, r_head};
        end
        r_link_rd <= link_mem[r_head];
    end

    // tracker memory, read at the incoming item's tag every cycle
    always_ff @(posedge i_clk) begin
        if (trk_we) begin
            trk_mem[r_head] <= trk_wdata;
        end
        r_trk_rd <= trk_mem[rd_tag];
    end

    assign o_busy   = (r_state == S_EXEC) || !i_rst_n;
    assign o_done   = r_done;
    assign o_result = r_result;

    `DTTC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, o_busy)
    `DTTC_ASSERT_NEXT(a_exec_done, i_clk, i_rst_n, r_state == S_EXEC, o_done)
    `DTTC_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    `DTTC_ASSERT_IMP(a_count_adv, i_clk, i_rst_n,
        o_done && (o_result.outcome == OC_OK || o_result.outcome == OC_FAULT ||
                   o_result.outcome == OC_REQUEUE || o_result.outcome == OC_SW_ERR),
        r_exp_count == 16'($past(r_exp_count) + 16'd1))

endmodule
